/* sv/i2c_target_byte_word_file_adapter_unit_assert.svh */
// Assertion macros shared by the adapter modules.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef I2C_TARGET_BYTE_WORD_FILE_ADAPTER_UNIT_ASSERT_SVH
`define I2C_TARGET_BYTE_WORD_FILE_ADAPTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define I2CTBWFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2CTBWFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/i2ctbwfa_pkg.sv */
`default_nettype none

package i2ctbwfa_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned REC_W   = 16;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned THR_W   = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CTRL_WR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_DONE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POST_TX    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CTRL_RD    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ZERO_DEPTH = 3'd4;
  localparam logic [CMD_W-1:0] CMD_POLL       = 3'd5;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ACK      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RX_BYTE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TX_BYTE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEPTH    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RECOVERY = 3'd4;

  // Configuration register indexes
  localparam logic REG_HANDLER_EN   = 1'b0;
  localparam logic REG_STUCK_THRESH = 1'b1;

  localparam logic [THR_W-1:0] THRESH_RESET = 4'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the accepted word
    logic exec;   // carry out the captured command
    logic step;   // emit the next drained byte
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic multi;  // this write-complete drains more than one byte
    logic more;   // bytes remain after the current drain step
  } dp_status_t;

endpackage

`default_nettype wire

/* sv/i2ctbwfa_ctrl.sv */
`default_nettype none
`include "i2c_target_byte_word_file_adapter_unit_assert.svh"

module i2ctbwfa_ctrl
  import i2ctbwfa_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  output logic            busy_o,
  input  wire dp_status_t sts_i,
  output ctl_cmd_t        ctl_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;
  ctl_cmd_t   ctl;

  always_comb begin
    state_d = state_q;
    ctl     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl.load = 1'b1;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        state_d  = sts_i.multi ? S_DRAIN : S_IDLE;
      end
      S_DRAIN: begin
        ctl.step = 1'b1;
        if (!sts_i.more) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign ctl_o  = ctl;

  `I2CTBWFA_ASSERT_NEXT(a_exec_follows_load, ctl_o.load, ctl_o.exec, "load not followed by exec")
  `I2CTBWFA_ASSERT_NEXT(a_drain_ends, (state_q == S_DRAIN) && !sts_i.more, state_q == S_IDLE, "drain overran")
  `I2CTBWFA_ASSERT_IMPL(a_no_load_busy, busy_o, !ctl_o.load, "word loaded while busy")

endmodule

`default_nettype wire

/* sv/i2ctbwfa_dpath.sv */
`default_nettype none
`include "i2c_target_byte_word_file_adapter_unit_assert.svh"

module i2ctbwfa_dpath
  import i2ctbwfa_pkg::*;
#(
  parameter int unsigned FILE_BYTES = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire  ctl_cmd_t     ctl_i,
  output dp_status_t         sts_o,
  input  wire  [CMD_W-1:0]   cmd_i,
  input  wire  [7:0]         data_byte_i,
  input  wire                sda_high_i,
  input  wire                host_on_i,
  input  wire                cfg_we_i,
  input  wire                cfg_index_i,
  input  wire  [CFG_W-1:0]   cfg_data_i,
  output logic               res_strobe_o,
  output logic [KIND_W-1:0]  kind_o,
  output logic [7:0]         result_byte_o,
  output logic               last_o,
  output logic [COUNT_W-1:0] count_o,
  output logic [REC_W-1:0]   recoveries_o
);

  localparam int unsigned PTR_W   = $clog2(FILE_BYTES);
  localparam int unsigned WORDS   = FILE_BYTES / 4;
  localparam int unsigned WADDR_W = PTR_W - 2;

  typedef logic [3:0][7:0] word_t;

  function automatic word_t tx_reset_word(input logic [WADDR_W-1:0] addr);
    word_t w;
    w = (addr == '0) ? '1 : '0;
    return w;
  endfunction

  // Captured command
  logic [CMD_W-1:0] cmd_q;
  logic [7:0]       data_q;
  logic             sda_q, host_q;

  // Configuration
  logic             hen_q;
  logic [THR_W-1:0] thr_q;

  // Pointers and counters
  logic [PTR_W-1:0] cw_q, cw_d, dw_q, dw_d, dr_q, dr_d, cr_q, cr_d;
  logic [PTR_W-1:0] remain_q, remain_d;
  logic [COUNT_W-1:0] run_q, run_d;
  logic [THR_W-1:0] lp_q, lp_d, lp_inc;
  logic [REC_W-1:0] rec_q, rec_d;
  logic [PTR_W-1:0] n_new, depth;

  // Register files
  word_t rx_mem [WORDS];
  word_t tx_mem [WORDS];
  word_t rx_rd_q, tx_rd_q, tx_word, tx_fill;
  logic [WORDS-1:0] tx_vld_q;
  logic  rx_we, tx_we, tx_clr0;

  // Result
  logic               out_ld;
  logic               strobe_q;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [7:0]         byte_q, byte_d;
  logic               last_q, last_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  dp_status_t         sts;

  assign n_new   = cw_q - dw_q;
  assign depth   = dr_q - cr_q;
  assign lp_inc  = lp_q + 4'd1;
  assign tx_word = tx_vld_q[cr_q[PTR_W-1:2]] ? tx_rd_q : tx_reset_word(cr_q[PTR_W-1:2]);

  always_comb begin
    tx_fill = tx_reset_word(dr_q[PTR_W-1:2]);
    tx_fill[dr_q[1:0]] = data_q;
  end

  always_comb begin
    cw_d     = cw_q;
    dw_d     = dw_q;
    dr_d     = dr_q;
    cr_d     = cr_q;
    remain_d = remain_q;
    run_d    = run_q;
    lp_d     = lp_q;
    rec_d    = rec_q;
    rx_we    = 1'b0;
    tx_we    = 1'b0;
    tx_clr0  = 1'b0;
    out_ld   = 1'b0;
    kind_d   = KIND_ACK;
    byte_d   = '0;
    last_d   = 1'b0;
    cnt_d    = '0;
    sts.multi = 1'b0;
    sts.more  = (remain_q != PTR_W'(1));
    if (ctl_i.step) begin
      out_ld   = 1'b1;
      kind_d   = KIND_RX_BYTE;
      byte_d   = rx_rd_q[dw_q[1:0]];
      last_d   = (remain_q == PTR_W'(1));
      cnt_d    = run_q;
      dw_d     = dw_q + PTR_W'(1);
      remain_d = remain_q - PTR_W'(1);
    end else if (ctl_i.exec) begin
      unique case (cmd_q)
        CMD_CTRL_WR: begin
          rx_we  = 1'b1;
          cw_d   = cw_q + PTR_W'(1);
          out_ld = 1'b1;
        end
        CMD_WR_DONE: begin
          lp_d   = '0;
          out_ld = 1'b1;
          if (hen_q) begin
            if (n_new == '0) begin
              last_d = 1'b1;
            end else begin
              kind_d    = KIND_RX_BYTE;
              byte_d    = rx_rd_q[dw_q[1:0]];
              last_d    = (n_new == PTR_W'(1));
              cnt_d     = COUNT_W'(n_new);
              run_d     = COUNT_W'(n_new);
              remain_d  = n_new - PTR_W'(1);
              dw_d      = dw_q + PTR_W'(1);
              sts.multi = (n_new != PTR_W'(1));
            end
          end
        end
        CMD_POST_TX: begin
          tx_we  = 1'b1;
          dr_d   = dr_q + PTR_W'(1);
          out_ld = 1'b1;
        end
        CMD_CTRL_RD: begin
          kind_d = KIND_TX_BYTE;
          byte_d = tx_word[cr_q[1:0]];
          cr_d   = cr_q + PTR_W'(1);
          out_ld = 1'b1;
        end
        CMD_ZERO_DEPTH: begin
          kind_d = KIND_DEPTH;
          cnt_d  = COUNT_W'(depth);
          dr_d   = cr_q;
          out_ld = 1'b1;
        end
        CMD_POLL: begin
          out_ld = 1'b1;
          if (!host_q || sda_q) begin
            lp_d = '0;
          end else if (lp_inc == thr_q) begin
            lp_d   = '0;
            rec_d  = rec_q + 16'd1;
            kind_d = KIND_RECOVERY;
            if (hen_q) begin
              cw_d    = '0;
              dw_d    = '0;
              dr_d    = '0;
              cr_d    = '0;
              tx_clr0 = 1'b1;
            end
          end else begin
            lp_d = lp_inc;
          end
        end
        default: begin
          out_ld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hen_q    <= 1'b0;
      thr_q    <= THRESH_RESET;
      cw_q     <= '0;
      dw_q     <= '0;
      dr_q     <= '0;
      cr_q     <= '0;
      remain_q <= '0;
      lp_q     <= '0;
      rec_q    <= '0;
      tx_vld_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_HANDLER_EN:   hen_q <= cfg_data_i[0];
          REG_STUCK_THRESH: thr_q <= cfg_data_i[THR_W-1:0];
          default:          hen_q <= hen_q;
        endcase
      end
      cw_q     <= cw_d;
      dw_q     <= dw_d;
      dr_q     <= dr_d;
      cr_q     <= cr_d;
      remain_q <= remain_d;
      lp_q     <= lp_d;
      rec_q    <= rec_d;
      strobe_q <= out_ld;
      if (tx_we) begin
        tx_vld_q[dr_q[PTR_W-1:2]] <= 1'b1;
      end else if (tx_clr0) begin
        tx_vld_q[0] <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_i;
      data_q <= data_byte_i;
      sda_q  <= sda_high_i;
      host_q <= host_on_i;
    end
    if (out_ld) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      last_q <= last_d;
      cnt_q  <= cnt_d;
    end
    run_q <= run_d;
  end

  // Receive file: byte-lane write, read at the next drain pointer
  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[cw_q[PTR_W-1:2]][cw_q[1:0]] <= data_q;
    end
    rx_rd_q <= rx_mem[dw_d[PTR_W-1:2]];
  end

  // Transmit file: lane write into a valid word, full fill otherwise
  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      if (tx_vld_q[dr_q[PTR_W-1:2]]) begin
        tx_mem[dr_q[PTR_W-1:2]][dr_q[1:0]] <= data_q;
      end else begin
        tx_mem[dr_q[PTR_W-1:2]] <= tx_fill;
      end
    end
    tx_rd_q <= tx_mem[cr_d[PTR_W-1:2]];
  end

  assign sts_o         = sts;
  assign res_strobe_o  = strobe_q;
  assign kind_o        = kind_q;
  assign result_byte_o = byte_q;
  assign last_o        = last_q;
  assign count_o       = cnt_q;
  assign recoveries_o  = rec_q;

  `I2CTBWFA_ASSERT_IMPL(a_strobe_source, strobe_q, $past(ctl_i.exec || ctl_i.step), "strobe without work")
  `I2CTBWFA_ASSERT_IMPL(a_drain_nonempty, ctl_i.step, remain_q != '0, "drain step with nothing left")
  `I2CTBWFA_ASSERT_IMPL(a_last_kind, strobe_q && last_q, (kind_q == KIND_RX_BYTE) || (kind_q == KIND_ACK), "last on wrong kind")

endmodule

`default_nettype wire

/* sv/i2c_target_byte_word_file_adapter_unit.sv */
`default_nettype none

// I2C target register-file adapter. Issue a command word by raising start
// while busy is low; the word is taken at that edge. Every defined command
// except write-complete answers exactly one result: the word passes the
// execute state, then res_strobe_o is high for one cycle, and the block
// takes no new word until it leaves the execute state. Write-complete with
// the handler enabled drains n new receive bytes, one byte per cycle,
// paced by the single registered read port of the receive file; busy
// stays high until the last byte is on the ports. Unused command codes
// hold busy through the execute state and give no result. The receiver
// cannot stall: each result is on the ports only for the cycle
// res_strobe_o is high. recoveries_o holds the running recovery total.
// Configuration writes are always accepted (cfg_ready_o is tied high) and
// should only be issued while the block is idle.
module i2c_target_byte_word_file_adapter_unit
  import i2ctbwfa_pkg::*;
#(
  parameter int unsigned FILE_BYTES = 64  // power of two, 8 to 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // Command channel
  input  wire                start,
  output logic               busy,
  input  wire  [CMD_W-1:0]   cmd_i,
  input  wire  [7:0]         data_byte_i,
  input  wire                sda_high_i,
  input  wire                host_on_i,
  // Configuration write channel
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire                cfg_index_i,
  input  wire  [CFG_W-1:0]   cfg_data_i,
  // Result channel
  output logic               res_strobe_o,
  output logic [KIND_W-1:0]  kind_o,
  output logic [7:0]         result_byte_o,
  output logic               last_o,
  output logic [COUNT_W-1:0] count_o,
  output logic [REC_W-1:0]   recoveries_o
);

  ctl_cmd_t   ctl;
  dp_status_t sts;

  // Registers are plain flops; never hold off a configuration word.
  assign cfg_ready_o = 1'b1;

  // Sequence load, execute and drain steps.
  i2ctbwfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  // Hold both register files, the four byte pointers, the poll counter and
  // the result register.
  i2ctbwfa_dpath #(
    .FILE_BYTES (FILE_BYTES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cmd_i         (cmd_i),
    .data_byte_i   (data_byte_i),
    .sda_high_i    (sda_high_i),
    .host_on_i     (host_on_i),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .res_strobe_o  (res_strobe_o),
    .kind_o        (kind_o),
    .result_byte_o (result_byte_o),
    .last_o        (last_o),
    .count_o       (count_o),
    .recoveries_o  (recoveries_o)
  );

endmodule

`default_nettype wire

/* tb/i2c_target_byte_word_file_adapter_unit_tb.sv */
module i2c_target_byte_word_file_adapter_unit_tb;
  import i2ctbwfa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FILE_BYTES   = 64;
  localparam int unsigned FILE_WORDS   = FILE_BYTES / 4;
  localparam int unsigned PTR_W        = $clog2(FILE_BYTES);
  localparam int          IDLE_PCT     = 7;
  localparam int          SETTLE_TICKS = 4;
  localparam int          LIMIT_CYCLES = 200000;
  localparam int          PHASE_WORDS  = 25;

  // Command codes the block ignores; no answer comes back for these.
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  // Random phases: drain enable and stuck threshold, extremes included.
  localparam logic             PHASE_DRAIN [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam logic [THR_W-1:0] PHASE_THR   [6] = '{4'd3, 4'd15, 4'd1, 4'd0, 4'd15, 4'd1};

  // One result word as it leaves the block.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [7:0]         data;
    logic               last;
    logic [COUNT_W-1:0] count;
    logic [REC_W-1:0]   rec;
  } answer_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_op_e;

  // One line of the directed script: either a command word or a register
  // write. typed rows carry the answer written out by hand.
  typedef struct packed {
    row_op_e          op;
    logic [CMD_W-1:0] cmd;
    logic [7:0]       data;
    logic             sda;
    logic             host;
    logic             idx;
    logic             typed;
    answer_t          want;
  } row_t;

  localparam answer_t NO_ANSWER = '0;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               start        = 1'b0;
  logic               busy;
  logic [CMD_W-1:0]   cmd_i        = CMD_CTRL_WR;
  logic [7:0]         data_byte_i  = 8'h00;
  logic               sda_high_i   = 1'b1;
  logic               host_on_i    = 1'b0;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i  = REG_HANDLER_EN;
  logic [CFG_W-1:0]   cfg_data_i   = '0;
  logic               res_strobe_o;
  logic [KIND_W-1:0]  kind_o;
  logic [7:0]         result_byte_o;
  logic               last_o;
  logic [COUNT_W-1:0] count_o;
  logic [REC_W-1:0]   recoveries_o;

  i2c_target_byte_word_file_adapter_unit #(
    .FILE_BYTES(FILE_BYTES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .data_byte_i  (data_byte_i),
    .sda_high_i   (sda_high_i),
    .host_on_i    (host_on_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .res_strobe_o (res_strobe_o),
    .kind_o       (kind_o),
    .result_byte_o(result_byte_o),
    .last_o       (last_o),
    .count_o      (count_o),
    .recoveries_o (recoveries_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Shadow copy of the adapter state
  // ---------------------------------------------------------------------
  logic [31:0]      rx_words [FILE_WORDS];
  logic [31:0]      tx_words [FILE_WORDS];
  logic [PTR_W-1:0] rx_head;     // controller write position
  logic [PTR_W-1:0] rx_tail;     // driver drain position
  logic [PTR_W-1:0] tx_head;     // driver post position
  logic [PTR_W-1:0] tx_tail;     // controller read position
  logic [3:0]       low_run;
  logic [REC_W-1:0] rec_total;
  logic             drain_on;
  logic [THR_W-1:0] stuck_limit;

  answer_t fresh_answers [$];    // answers of the word just accepted
  answer_t pending_answers [$];  // answers still owed by the block

  int  errors          = 0;
  int  words_sent      = 0;
  int  answers_checked = 0;
  int  recoveries_seen = 0;
  int  cycles          = 0;
  bit  no_gaps         = 1'b0;

  function automatic logic [7:0] lane_of(logic [31:0] w, logic [1:0] lane);
    return w[lane*8 +: 8];
  endfunction

  function automatic logic [31:0] with_lane(logic [31:0] w, logic [1:0] lane, logic [7:0] b);
    w[lane*8 +: 8] = b;
    return w;
  endfunction

  function automatic answer_t make_answer(logic [KIND_W-1:0] kind, logic [7:0] data,
                                          logic last, logic [COUNT_W-1:0] count);
    answer_t a;
    a.kind  = kind;
    a.data  = data;
    a.last  = last;
    a.count = count;
    a.rec   = rec_total;
    return a;
  endfunction

  // Pointer restart shared by reset and a recovery with draining on.
  function automatic void restart_pointers();
    rx_head     = '0;
    rx_tail     = '0;
    tx_head     = '0;
    tx_tail     = '0;
    low_run     = '0;
    tx_words[0] = '1;
  endfunction

  // Work out the answers of one command word and advance the shadow state.
  function automatic void predict_answers(logic [CMD_W-1:0] c, logic [7:0] d,
                                          logic sda, logic host);
    logic [PTR_W-1:0] n;
    logic [PTR_W-1:0] depth;
    fresh_answers.delete();
    case (c)
      CMD_CTRL_WR: begin
        rx_words[rx_head[PTR_W-1:2]] = with_lane(rx_words[rx_head[PTR_W-1:2]], rx_head[1:0], d);
        rx_head = rx_head + 1'b1;
        fresh_answers.push_back(make_answer(KIND_ACK, 8'h00, 1'b0, '0));
      end
      CMD_WR_DONE: begin
        low_run = '0;
        n = rx_head - rx_tail;
        if (!drain_on) begin
          fresh_answers.push_back(make_answer(KIND_ACK, 8'h00, 1'b0, '0));
        end else if (n == 0) begin
          fresh_answers.push_back(make_answer(KIND_ACK, 8'h00, 1'b1, '0));
        end else begin
          for (int i = 0; i < int'(n); i++) begin
            fresh_answers.push_back(make_answer(KIND_RX_BYTE,
                lane_of(rx_words[rx_tail[PTR_W-1:2]], rx_tail[1:0]), i == int'(n) - 1, n));
            rx_tail = rx_tail + 1'b1;
          end
        end
      end
      CMD_POST_TX: begin
        tx_words[tx_head[PTR_W-1:2]] = with_lane(tx_words[tx_head[PTR_W-1:2]], tx_head[1:0], d);
        tx_head = tx_head + 1'b1;
        fresh_answers.push_back(make_answer(KIND_ACK, 8'h00, 1'b0, '0));
      end
      CMD_CTRL_RD: begin
        fresh_answers.push_back(make_answer(KIND_TX_BYTE,
            lane_of(tx_words[tx_tail[PTR_W-1:2]], tx_tail[1:0]), 1'b0, '0));
        tx_tail = tx_tail + 1'b1;
      end
      CMD_ZERO_DEPTH: begin
        depth = tx_head - tx_tail;
        if (depth != 0) tx_head = tx_tail;
        fresh_answers.push_back(make_answer(KIND_DEPTH, 8'h00, 1'b0, depth));
      end
      CMD_POLL: begin
        if (!host || sda) begin
          low_run = '0;
          fresh_answers.push_back(make_answer(KIND_ACK, 8'h00, 1'b0, '0));
        end else begin
          low_run = low_run + 1'b1;
          if (low_run == stuck_limit) begin
            low_run   = '0;
            rec_total = rec_total + 1'b1;
            if (drain_on) restart_pointers();
            fresh_answers.push_back(make_answer(KIND_RECOVERY, 8'h00, 1'b0, '0));
          end else begin
            fresh_answers.push_back(make_answer(KIND_ACK, 8'h00, 1'b0, '0));
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Command and register drivers
  // ---------------------------------------------------------------------

  // Issue one command word; start stays high after acceptance so that the
  // next word can follow without a bubble.
  task automatic issue_word(input logic [CMD_W-1:0] c, input logic [7:0] d, input logic sda,
                            input logic host, input logic typed, input answer_t want);
    if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start       <= 1'b1;
    cmd_i       <= c;
    data_byte_i <= d;
    sda_high_i  <= sda;
    host_on_i   <= host;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_answers(c, d, sda, host);
    if (typed) begin
      pending_answers.push_back(want);
    end else begin
      foreach (fresh_answers[i]) pending_answers.push_back(fresh_answers[i]);
    end
    if (c <= CMD_POLL) words_sent++;
  endtask

  // Drop start and wait until every owed answer is in, plus a few cycles
  // for a trailing ignored word.
  task automatic settle();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == REG_HANDLER_EN) drain_on = value[0];
    else stuck_limit = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A run of controller writes closed by write-complete.
  task automatic rx_burst(input int k);
    repeat (k) issue_word(CMD_CTRL_WR, $urandom, $urandom_range(1), $urandom_range(1),
                          1'b0, NO_ANSWER);
    issue_word(CMD_WR_DONE, $urandom, $urandom_range(1), $urandom_range(1), 1'b0, NO_ANSWER);
  endtask

  // ---------------------------------------------------------------------
  // Result checker: the receiver never stalls, so sample on every strobe
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && res_strobe_o === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got kind %0d byte %0h",
                 $time, kind_o, result_byte_o);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("result_byte", want.data, result_byte_o);
        check_field("last", want.last, last_o);
        check_field("count", want.count, count_o);
        check_field("recoveries", want.rec, recoveries_o);
        if (want.kind == KIND_RECOVERY) recoveries_seen++;
        answers_checked++;
      end
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("i2c_target_byte_word_file_adapter_unit_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed script. Starts from reset: draining off, threshold three.
  // ---------------------------------------------------------------------
  row_t script [25] = '{
    // read before any post: word zero resets to all ones
    '{ROW_WORD, CMD_CTRL_RD,    8'h00, 1'b0, 1'b0, REG_HANDLER_EN, 1'b1,
      '{KIND_TX_BYTE, 8'hff, 1'b0, 6'd0, 16'd0}},
    // depth wraps negative after the read, then moves the post pointer to the read pointer
    '{ROW_WORD, CMD_ZERO_DEPTH, 8'h00, 1'b0, 1'b0, REG_HANDLER_EN, 1'b0, NO_ANSWER},
    '{ROW_WORD, CMD_CTRL_WR,    8'h00, 1'b0, 1'b1, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b0, 6'd0, 16'd0}},
    '{ROW_WORD, CMD_CTRL_WR,    8'hff, 1'b1, 1'b0, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b0, 6'd0, 16'd0}},
    // draining off: plain ack, no pointer moves
    '{ROW_WORD, CMD_WR_DONE,    8'hff, 1'b1, 1'b1, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b0, 6'd0, 16'd0}},
    '{ROW_WORD, CMD_POST_TX,    8'ha5, 1'b0, 1'b0, REG_HANDLER_EN, 1'b0, NO_ANSWER},
    '{ROW_WORD, CMD_CTRL_RD,    8'h00, 1'b0, 1'b0, REG_HANDLER_EN, 1'b0, NO_ANSWER},
    // SDA high, then host off: both clear the low count
    '{ROW_WORD, CMD_POLL,       8'h00, 1'b1, 1'b1, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b0, 6'd0, 16'd0}},
    '{ROW_WORD, CMD_POLL,       8'hff, 1'b0, 1'b0, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b0, 6'd0, 16'd0}},
    '{ROW_WORD, CMD_POLL,       8'h00, 1'b0, 1'b1, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b0, 6'd0, 16'd0}},
    '{ROW_WORD, CMD_POLL,       8'h00, 1'b0, 1'b1, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b0, 6'd0, 16'd0}},
    // third low poll: recovery, pointers kept with draining off
    '{ROW_WORD, CMD_POLL,       8'h00, 1'b0, 1'b1, REG_HANDLER_EN, 1'b1,
      '{KIND_RECOVERY, 8'h00, 1'b0, 6'd0, 16'd1}},
    // unused codes give nothing back
    '{ROW_WORD, CMD_SPARE6,     8'h5a, 1'b1, 1'b1, REG_HANDLER_EN, 1'b0, NO_ANSWER},
    '{ROW_WORD, CMD_SPARE7,     8'ha5, 1'b0, 1'b1, REG_HANDLER_EN, 1'b0, NO_ANSWER},
    '{ROW_REG,  CMD_CTRL_WR,    8'h01, 1'b0, 1'b0, REG_HANDLER_EN, 1'b0, NO_ANSWER},
    // drain the two bytes written above
    '{ROW_WORD, CMD_WR_DONE,    8'h00, 1'b0, 1'b0, REG_HANDLER_EN, 1'b0, NO_ANSWER},
    // nothing new: empty drain
    '{ROW_WORD, CMD_WR_DONE,    8'h00, 1'b0, 1'b0, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b1, 6'd0, 16'd1}},
    '{ROW_WORD, CMD_CTRL_WR,    8'h5a, 1'b0, 1'b0, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b0, 6'd0, 16'd1}},
    '{ROW_WORD, CMD_POLL,       8'h00, 1'b0, 1'b1, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b0, 6'd0, 16'd1}},
    '{ROW_WORD, CMD_POLL,       8'h00, 1'b0, 1'b1, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b0, 6'd0, 16'd1}},
    // recovery with draining on restarts all pointers
    '{ROW_WORD, CMD_POLL,       8'h00, 1'b0, 1'b1, REG_HANDLER_EN, 1'b1,
      '{KIND_RECOVERY, 8'h00, 1'b0, 6'd0, 16'd2}},
    '{ROW_WORD, CMD_CTRL_RD,    8'h00, 1'b0, 1'b0, REG_HANDLER_EN, 1'b1,
      '{KIND_TX_BYTE, 8'hff, 1'b0, 6'd0, 16'd2}},
    '{ROW_WORD, CMD_WR_DONE,    8'h00, 1'b0, 1'b0, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b1, 6'd0, 16'd2}},
    '{ROW_WORD, CMD_POST_TX,    8'h3c, 1'b0, 1'b0, REG_HANDLER_EN, 1'b1,
      '{KIND_ACK, 8'h00, 1'b0, 6'd0, 16'd2}},
    // post and read pointers meet: depth zero
    '{ROW_WORD, CMD_ZERO_DEPTH, 8'h00, 1'b0, 1'b0, REG_HANDLER_EN, 1'b1,
      '{KIND_DEPTH, 8'h00, 1'b0, 6'd0, 16'd2}}
  };

  initial begin
    int               pick;
    int               m;
    int               runs;
    int               phase_start;
    logic [CFG_W-1:0] en_value;

    // Mirror the reset state: receive file is never read before written.
    foreach (rx_words[i]) rx_words[i] = '0;
    foreach (tx_words[i]) tx_words[i] = '0;
    restart_pointers();
    rec_total   = '0;
    drain_on    = 1'b0;
    stuck_limit = THRESH_RESET;

    // Hold reset low, then release it at an edge.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed script.
    foreach (script[r]) begin
      if (script[r].op == ROW_REG) begin
        settle();
        write_register(script[r].idx, script[r].data[CFG_W-1:0]);
      end else begin
        issue_word(script[r].cmd, script[r].data, script[r].sda, script[r].host,
                   script[r].typed, script[r].want);
      end
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < 6; p++) begin
      settle();
      en_value    = $urandom;
      en_value[0] = PHASE_DRAIN[p];
      write_register(REG_HANDLER_EN, en_value);
      write_register(REG_STUCK_THRESH, PHASE_THR[p]);
      // keep phase two free of sender gaps
      no_gaps = (p == 2);
      if (p == 0) begin
        // longest drain, then a full lap that leaves nothing new
        rx_burst(FILE_BYTES - 1);
        rx_burst(FILE_BYTES);
      end
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          rx_burst(($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6));
        end else if (pick < 60) begin
          // posts, reads, then maybe a depth check
          m = $urandom_range(1, 8);
          repeat (m) issue_word(CMD_POST_TX, $urandom, $urandom_range(1), $urandom_range(1),
                                1'b0, NO_ANSWER);
          repeat ($urandom_range(0, m + 2))
            issue_word(CMD_CTRL_RD, $urandom, $urandom_range(1), $urandom_range(1),
                       1'b0, NO_ANSWER);
          if ($urandom_range(1))
            issue_word(CMD_ZERO_DEPTH, $urandom, $urandom_range(1), $urandom_range(1),
                       1'b0, NO_ANSWER);
        end else if (pick < 75) begin
          // stuck-bus run; a zero threshold needs a full wrap of the count
          runs = (PHASE_THR[p] == 0) ? 16 : PHASE_THR[p];
          if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(0, runs - 1))
              issue_word(CMD_POLL, $urandom, 1'b0, 1'b1, 1'b0, NO_ANSWER);
            case ($urandom_range(2))
              0: issue_word(CMD_POLL, $urandom, 1'b1, $urandom_range(1), 1'b0, NO_ANSWER);
              1: issue_word(CMD_POLL, $urandom, 1'b0, 1'b0, 1'b0, NO_ANSWER);
              default: issue_word(CMD_WR_DONE, $urandom, 1'b0, 1'b1, 1'b0, NO_ANSWER);
            endcase
          end else begin
            repeat (runs) issue_word(CMD_POLL, $urandom, 1'b0, 1'b1, 1'b0, NO_ANSWER);
          end
        end else begin
          // noise: any code, any fields
          issue_word($urandom_range(7), $urandom, $urandom_range(1), $urandom_range(1),
                     1'b0, NO_ANSWER);
        end
      end
    end

    // Drain everything owed, then allow a short tail for stray words.
    settle();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d command words over 6 register settings plus the directed script.",
             words_sent);
    $display("Checked %0d result words, %0d of them recoveries.",
             answers_checked, recoveries_seen);
    if (errors == 0) begin
      $display("i2c_target_byte_word_file_adapter_unit_tb: PASS");
    end else begin
      $display("i2c_target_byte_word_file_adapter_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/i2ctbwfa_pkg.sv
sv/i2ctbwfa_ctrl.sv
sv/i2ctbwfa_dpath.sv
sv/i2c_target_byte_word_file_adapter_unit.sv
tb/i2c_target_byte_word_file_adapter_unit_tb.sv
